### rtl/core/banked_registers_exception_entry_macros.svh
// Assertion macros for the banked register file with exception entry.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef BANKED_REGISTERS_EXCEPTION_ENTRY_MACROS_SVH
`define BANKED_REGISTERS_EXCEPTION_ENTRY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bre_pkg.sv
// Types, codes and slot mapping for the banked register file.
// No dependencies; imported by the top level.
`default_nettype none

package bre_pkg;

  typedef enum logic [2:0] {
    ACT_READ  = 3'd0,
    ACT_WRITE = 3'd1,
    ACT_MODE  = 3'd2,
    ACT_THUMB = 3'd3,
    ACT_EXC   = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    EXC_RESET = 3'd0,
    EXC_UND   = 3'd1,
    EXC_SWI   = 3'd2,
    EXC_PABT  = 3'd3,
    EXC_DABT  = 3'd4,
    EXC_IRQ   = 3'd5,
    EXC_FIQ   = 3'd6
  } exc_kind_e;

  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;

  // Only the low byte of the status word is ever non-zero.
  localparam int unsigned STATUS_W = 8;
  localparam int unsigned BIT_T = 5;
  localparam int unsigned BIT_F = 6;
  localparam int unsigned BIT_I = 7;
  localparam logic [STATUS_W-1:0] STATUS_RESET = 8'hD3;

  // Physical register slots.
  localparam int unsigned NUM_SLOTS = 31;
  localparam int unsigned SLOT_W = 5;
  localparam logic [SLOT_W-1:0] SLOT_PC     = 5'd15;
  localparam logic [SLOT_W-1:0] SLOT_FIQ_R8 = 5'd16;
  localparam logic [SLOT_W-1:0] SLOT_IRQ_SP = 5'd23;
  localparam logic [SLOT_W-1:0] SLOT_SVC_SP = 5'd25;
  localparam logic [SLOT_W-1:0] SLOT_ABT_SP = 5'd27;
  localparam logic [SLOT_W-1:0] SLOT_UND_SP = 5'd29;

  // Saved status bank.
  localparam int unsigned NUM_SPSR = 5;
  localparam int unsigned SPSR_IDX_W = 3;
  localparam logic [SPSR_IDX_W-1:0] SPSR_FIQ = 3'd0;
  localparam logic [SPSR_IDX_W-1:0] SPSR_IRQ = 3'd1;
  localparam logic [SPSR_IDX_W-1:0] SPSR_SVC = 3'd2;
  localparam logic [SPSR_IDX_W-1:0] SPSR_ABT = 3'd3;
  localparam logic [SPSR_IDX_W-1:0] SPSR_UND = 3'd4;

  localparam logic [31:0] VEC_HIGH_BASE = 32'hFFFF0000;
  localparam logic [7:0] VEC_UND  = 8'h04;
  localparam logic [7:0] VEC_SWI  = 8'h08;
  localparam logic [7:0] VEC_PABT = 8'h0C;
  localparam logic [7:0] VEC_DABT = 8'h10;
  localparam logic [7:0] VEC_IRQ  = 8'h18;
  localparam logic [7:0] VEC_FIQ  = 8'h1C;

  localparam logic [2:0] RET_SAME  = 3'd0;
  localparam logic [2:0] RET_ARM   = 3'd4;
  localparam logic [2:0] RET_THUMB = 3'd6;

  localparam logic [3:0] REG_R8 = 4'd8;
  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_LR = 4'd14;

  function automatic logic [SLOT_W-1:0] phys_slot(logic [3:0] r, logic [4:0] mode);
    logic [SLOT_W-1:0] s;
    s = {1'b0, r};
    if (mode == MODE_FIQ && r >= REG_R8 && r <= REG_LR) begin
      s = SLOT_FIQ_R8 + SLOT_W'(r - REG_R8);
    end else if (r == REG_SP || r == REG_LR) begin
      case (mode)
        MODE_IRQ: s = SLOT_IRQ_SP + SLOT_W'(r - REG_SP);
        MODE_SVC: s = SLOT_SVC_SP + SLOT_W'(r - REG_SP);
        MODE_ABT: s = SLOT_ABT_SP + SLOT_W'(r - REG_SP);
        MODE_UND: s = SLOT_UND_SP + SLOT_W'(r - REG_SP);
        default:  s = {1'b0, r};
      endcase
    end
    return s;
  endfunction

  function automatic logic has_spsr(logic [4:0] mode);
    return mode == MODE_FIQ || mode == MODE_IRQ || mode == MODE_SVC ||
           mode == MODE_ABT || mode == MODE_UND;
  endfunction

  function automatic logic [SPSR_IDX_W-1:0] spsr_idx(logic [4:0] mode);
    logic [SPSR_IDX_W-1:0] i;
    case (mode)
      MODE_FIQ: i = SPSR_FIQ;
      MODE_IRQ: i = SPSR_IRQ;
      MODE_SVC: i = SPSR_SVC;
      MODE_ABT: i = SPSR_ABT;
      default:  i = SPSR_UND;
    endcase
    return i;
  endfunction

endpackage

`default_nettype wire

### rtl/core/bre_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bre_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 31,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/banked_registers_exception_entry.sv
// Banked register file with mode switching and exception entry.
// Each accepted word's result word is registered and is presented in the cycle after acceptance.
// Throughput: one word per cycle while results are taken; every action,
// register reads included, needs at most one register-RAM access.
// Reset: status 0xD3 (supervisor, I and F set), r15 at the high vector base,
// high vectors on; register slots read as zero until first written.
`default_nettype none

module banked_registers_exception_entry
  import bre_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,
  // Input channel.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [3:0]  reg_index_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [4:0]  new_mode_i,
  input  wire logic        thumb_flag_i,
  input  wire logic [2:0]  exception_kind_i,
  // Output channel.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      read_data_o,
  output logic [31:0]      program_counter_o,
  output logic [4:0]       current_mode_o,
  output logic             thumb_state_o,
  output logic             irq_masked_o,
  output logic             fiq_masked_o,
  output logic             exception_taken_o,
  output logic [31:0]      saved_status_o,
  output logic [31:0]      status_word_o
);

`include "banked_registers_exception_entry_macros.svh"

  logic                high_vectors_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [31:0]         pc_q, pc_d;
  logic [STATUS_W-1:0] spsr_q [NUM_SPSR];
  logic [STATUS_W-1:0] spsr_d [NUM_SPSR];
  logic [NUM_SLOTS-1:0] slot_valid_q;

  logic        out_valid_q;
  logic        taken_q, taken_d;
  logic        rd_ram_q;
  logic        rd_valid_q;
  logic [31:0] rd_hold_q, rd_hold_d;

  logic              accept;
  logic [SLOT_W-1:0] slot;
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [31:0]       ram_rdata;
  logic [31:0]       vbase;

  logic              enter;
  logic [4:0]        tgt_mode;
  logic [2:0]        ret_off;
  logic [7:0]        vec_off;
  logic              set_f;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  assign slot  = phys_slot(reg_index_i, status_q[4:0]);
  assign vbase = high_vectors_q ? VEC_HIGH_BASE : '0;

  // Exception decode: target mode, return offset and vector offset.
  always_comb begin
    enter    = 1'b0;
    tgt_mode = MODE_UND;
    ret_off  = RET_SAME;
    vec_off  = VEC_UND;
    set_f    = 1'b0;
    unique case (exception_kind_i)
      EXC_UND: begin
        enter = 1'b1;
      end
      EXC_SWI: begin
        enter    = 1'b1;
        tgt_mode = MODE_SVC;
        vec_off  = VEC_SWI;
      end
      EXC_PABT: begin
        enter    = 1'b1;
        tgt_mode = MODE_ABT;
        ret_off  = RET_ARM;
        vec_off  = VEC_PABT;
      end
      EXC_DABT: begin
        enter    = 1'b1;
        tgt_mode = MODE_ABT;
        ret_off  = status_q[BIT_T] ? RET_THUMB : RET_ARM;
        vec_off  = VEC_DABT;
      end
      EXC_IRQ: begin
        enter    = !status_q[BIT_I];
        tgt_mode = MODE_IRQ;
        ret_off  = RET_ARM;
        vec_off  = VEC_IRQ;
      end
      EXC_FIQ: begin
        enter    = !status_q[BIT_F];
        tgt_mode = MODE_FIQ;
        ret_off  = RET_ARM;
        vec_off  = VEC_FIQ;
        set_f    = 1'b1;
      end
      default: begin
        enter = 1'b0;
      end
    endcase
  end

  // Next state for one word.
  always_comb begin
    status_d  = status_q;
    pc_d      = pc_q;
    spsr_d    = spsr_q;
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = write_data_i;
    taken_d   = 1'b0;
    rd_hold_d = '0;
    unique case (action_i)
      ACT_READ: begin
        rd_hold_d = pc_q;
      end
      ACT_WRITE: begin
        if (slot == SLOT_PC) begin
          pc_d = write_data_i;
        end else begin
          ram_we = 1'b1;
        end
      end
      ACT_MODE: begin
        status_d[4:0] = new_mode_i;
      end
      ACT_THUMB: begin
        status_d[BIT_T] = thumb_flag_i;
      end
      ACT_EXC: begin
        if (exception_kind_i == EXC_RESET) begin
          taken_d         = 1'b1;
          status_d[4:0]   = MODE_SVC;
          status_d[BIT_T] = 1'b0;
          status_d[BIT_I] = 1'b1;
          status_d[BIT_F] = 1'b1;
          pc_d            = vbase;
        end else if (enter) begin
          taken_d                  = 1'b1;
          ram_we                   = 1'b1;
          ram_waddr                = phys_slot(REG_LR, tgt_mode);
          ram_wdata                = pc_q + {29'b0, ret_off};
          spsr_d[spsr_idx(tgt_mode)] = status_q;
          status_d[4:0]            = tgt_mode;
          status_d[BIT_T]          = 1'b0;
          status_d[BIT_I]          = 1'b1;
          status_d[BIT_F]          = status_q[BIT_F] | set_f;
          pc_d                     = vbase | {24'b0, vec_off};
        end
      end
      default: begin
        taken_d = 1'b0;
      end
    endcase
  end

  assign ram_re = accept && action_i == ACT_READ && slot != SLOT_PC;

  bre_ram #(
    .Width (32),
    .Depth (NUM_SLOTS)
  ) u_regs (
    .clk_i   (clk_i),
    .we_i    (accept && ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_vectors_q <= 1'b1;
      status_q       <= STATUS_RESET;
      pc_q           <= VEC_HIGH_BASE;
      spsr_q         <= '{default: '0};
      slot_valid_q   <= '0;
      out_valid_q    <= 1'b0;
      taken_q        <= 1'b0;
      rd_ram_q       <= 1'b0;
      rd_valid_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        high_vectors_q <= cfg_data_i;
      end
      if (accept) begin
        status_q    <= status_d;
        pc_q        <= pc_d;
        spsr_q      <= spsr_d;
        taken_q     <= taken_d;
        rd_ram_q    <= ram_re;
        rd_valid_q  <= slot_valid_q[slot];
        if (ram_we) begin
          slot_valid_q[ram_waddr] <= 1'b1;
        end
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_hold_q <= (action_i == ACT_READ) ? rd_hold_d : '0;
    end
  end

  // The state only moves on when the pending result word is taken, so the
  // state registers themselves carry the post-step view of the result.
  assign out_valid_o       = out_valid_q;
  assign read_data_o       = rd_ram_q ? (rd_valid_q ? ram_rdata : '0) : rd_hold_q;
  assign program_counter_o = pc_q;
  assign current_mode_o    = status_q[4:0];
  assign thumb_state_o     = status_q[BIT_T];
  assign irq_masked_o      = status_q[BIT_I];
  assign fiq_masked_o      = status_q[BIT_F];
  assign exception_taken_o = taken_q;
  assign status_word_o     = {24'b0, status_q};
  assign saved_status_o    = has_spsr(status_q[4:0]) ?
                             {24'b0, spsr_q[spsr_idx(status_q[4:0])]} : '0;

  `BRE_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_o, "accepted word produced no result")
  `BRE_ASSERT_NOW(a_no_overrun, out_valid_o && !out_ready_i, !in_ready_o, "input taken over a held result")
  `BRE_ASSERT_NOW(a_entry_masks, out_valid_o && exception_taken_o, irq_masked_o && !thumb_state_o, "exception entry left I clear or T set")
  `BRE_ASSERT_NOW(a_fiq_entry, out_valid_o && exception_taken_o && current_mode_o == MODE_FIQ, fiq_masked_o, "FIQ entry left F clear")

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking bench for the banked register file with exception entry.
// Needs bre_pkg and banked_registers_exception_entry; a local predictor checks every result word.
`timescale 1ns / 100ps

module testbench;
  import bre_pkg::*;

  localparam logic [4:0] MODE_SYS = 5'h1F;
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST = 3'd7;
  localparam logic [2:0] EXC_NONE = 3'd7;
  localparam int unsigned RANDOM_OPS = 450;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  reg_idx;
    logic [31:0] wdata;
    logic [4:0]  mode;
    logic        thumb;
    logic [2:0]  kind;
  } op_word_t;

  typedef struct packed {
    logic [31:0] rd;
    logic [31:0] pc;
    logic [4:0]  mode;
    logic        thumb;
    logic        irq_m;
    logic        fiq_m;
    logic        taken;
    logic [31:0] spsr;
    logic [31:0] cpsr;
  } reg_view_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  action_i = '0;
  logic [3:0]  reg_index_i = '0;
  logic [31:0] write_data_i = '0;
  logic [4:0]  new_mode_i = '0;
  logic        thumb_flag_i = 1'b0;
  logic [2:0]  exception_kind_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] read_data_o;
  logic [31:0] program_counter_o;
  logic [4:0]  current_mode_o;
  logic        thumb_state_o;
  logic        irq_masked_o;
  logic        fiq_masked_o;
  logic        exception_taken_o;
  logic [31:0] saved_status_o;
  logic [31:0] status_word_o;

  // Predictor state: physical registers, status, saved status bank, vector select.
  logic [31:0] regs_m [NUM_SLOTS];
  logic [31:0] cpsr_m;
  logic [31:0] spsr_m [NUM_SPSR];
  logic        vec_high_m;

  op_word_t  op_words[$];
  reg_view_t predicted_views[$];
  int        mismatches = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  bit        in_taken = 1'b0;
  bit        calm = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  banked_registers_exception_entry u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .reg_index_i      (reg_index_i),
    .write_data_i     (write_data_i),
    .new_mode_i       (new_mode_i),
    .thumb_flag_i     (thumb_flag_i),
    .exception_kind_i (exception_kind_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .read_data_o      (read_data_o),
    .program_counter_o(program_counter_o),
    .current_mode_o   (current_mode_o),
    .thumb_state_o    (thumb_state_o),
    .irq_masked_o     (irq_masked_o),
    .fiq_masked_o     (fiq_masked_o),
    .exception_taken_o(exception_taken_o),
    .saved_status_o   (saved_status_o),
    .status_word_o    (status_word_o)
  );

  // Maps a visible register number to its physical slot in the given mode.
  function automatic int bank_slot(logic [3:0] r, logic [4:0] mode);
    if (mode == MODE_FIQ && r >= REG_R8 && r <= REG_LR) begin
      return int'(SLOT_FIQ_R8) + int'(r - REG_R8);
    end
    if (r == REG_SP || r == REG_LR) begin
      case (mode)
        MODE_IRQ: return int'(SLOT_IRQ_SP) + int'(r - REG_SP);
        MODE_SVC: return int'(SLOT_SVC_SP) + int'(r - REG_SP);
        MODE_ABT: return int'(SLOT_ABT_SP) + int'(r - REG_SP);
        MODE_UND: return int'(SLOT_UND_SP) + int'(r - REG_SP);
        default: ;
      endcase
    end
    return int'(r);
  endfunction

  // Saved status entry of a mode, or -1 where the mode has none.
  function automatic int saved_slot(logic [4:0] mode);
    case (mode)
      MODE_FIQ: return int'(SPSR_FIQ);
      MODE_IRQ: return int'(SPSR_IRQ);
      MODE_SVC: return int'(SPSR_SVC);
      MODE_ABT: return int'(SPSR_ABT);
      MODE_UND: return int'(SPSR_UND);
      default:  return -1;
    endcase
  endfunction

  function automatic logic [31:0] vector_base();
    return vec_high_m ? VEC_HIGH_BASE : 32'h0;
  endfunction

  task automatic enter_exception(logic [4:0] mode, logic [31:0] ret, logic [7:0] offset,
                                 bit mask_fiq);
    int s;
    s = saved_slot(mode);
    regs_m[bank_slot(REG_LR, mode)] = ret;
    if (s >= 0) begin
      spsr_m[s] = cpsr_m;
    end
    cpsr_m = {cpsr_m[31:5], mode};
    cpsr_m[BIT_T] = 1'b0;
    cpsr_m[BIT_I] = 1'b1;
    if (mask_fiq) begin
      cpsr_m[BIT_F] = 1'b1;
    end
    regs_m[SLOT_PC] = vector_base() + 32'(offset);
  endtask

  // Applies one accepted word to the predicted state and queues the expected view.
  task automatic step_register_file(op_word_t w);
    reg_view_t v;
    logic [31:0] pc;
    int s;
    v = '0;
    pc = regs_m[SLOT_PC];
    case (w.action)
      ACT_READ:  v.rd = regs_m[bank_slot(w.reg_idx, cpsr_m[4:0])];
      ACT_WRITE: regs_m[bank_slot(w.reg_idx, cpsr_m[4:0])] = w.wdata;
      ACT_MODE:  cpsr_m = {cpsr_m[31:5], w.mode};
      ACT_THUMB: cpsr_m[BIT_T] = w.thumb;
      ACT_EXC: begin
        v.taken = 1'b1;
        case (w.kind)
          EXC_RESET: begin
            cpsr_m = {cpsr_m[31:5], MODE_SVC};
            cpsr_m[BIT_T] = 1'b0;
            cpsr_m[BIT_I] = 1'b1;
            cpsr_m[BIT_F] = 1'b1;
            regs_m[SLOT_PC] = vector_base();
          end
          EXC_UND:  enter_exception(MODE_UND, pc, VEC_UND, 1'b0);
          EXC_SWI:  enter_exception(MODE_SVC, pc, VEC_SWI, 1'b0);
          EXC_PABT: enter_exception(MODE_ABT, pc + 32'(RET_ARM), VEC_PABT, 1'b0);
          EXC_DABT: enter_exception(MODE_ABT,
                                    pc + (cpsr_m[BIT_T] ? 32'(RET_THUMB) : 32'(RET_ARM)),
                                    VEC_DABT, 1'b0);
          EXC_IRQ: begin
            if (cpsr_m[BIT_I]) begin
              v.taken = 1'b0;
            end else begin
              enter_exception(MODE_IRQ, pc + 32'(RET_ARM), VEC_IRQ, 1'b0);
            end
          end
          EXC_FIQ: begin
            if (cpsr_m[BIT_F]) begin
              v.taken = 1'b0;
            end else begin
              enter_exception(MODE_FIQ, pc + 32'(RET_ARM), VEC_FIQ, 1'b1);
            end
          end
          default: v.taken = 1'b0;
        endcase
      end
      default: ;
    endcase
    s = saved_slot(cpsr_m[4:0]);
    v.pc = regs_m[SLOT_PC];
    v.mode = cpsr_m[4:0];
    v.thumb = cpsr_m[BIT_T];
    v.irq_m = cpsr_m[BIT_I];
    v.fiq_m = cpsr_m[BIT_F];
    v.spsr = (s >= 0) ? spsr_m[s] : 32'h0;
    v.cpsr = cpsr_m;
    predicted_views.push_back(v);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic op_word_t make_op(logic [2:0] act, logic [3:0] r, logic [31:0] d,
                                       logic [4:0] m, logic t, logic [2:0] k);
    op_word_t w;
    w.action = act;
    w.reg_idx = r;
    w.wdata = d;
    w.mode = m;
    w.thumb = t;
    w.kind = k;
    return w;
  endfunction

  // Mostly well-formed traffic; unused codes and odd mode values are mixed in.
  function automatic op_word_t random_op();
    op_word_t w;
    int pick;
    w.action = ACT_READ;
    w.reg_idx = 4'($urandom_range(0, 15));
    w.wdata = $urandom;
    w.mode = 5'($urandom_range(0, 31));
    w.thumb = 1'($urandom_range(0, 1));
    w.kind = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      w.action = ACT_READ;
    end else if (pick < 50) begin
      w.action = ACT_WRITE;
      case ($urandom_range(0, 7))
        0: w.wdata = 32'h0;
        1: w.wdata = 32'hFFFF_FFFF;
        default: ;
      endcase
    end else if (pick < 65) begin
      w.action = ACT_MODE;
      case ($urandom_range(0, 9))
        0: w.mode = MODE_USR;
        1: w.mode = MODE_FIQ;
        2: w.mode = MODE_IRQ;
        3: w.mode = MODE_SVC;
        4: w.mode = MODE_ABT;
        5: w.mode = MODE_UND;
        6: w.mode = MODE_SYS;
        7: w.mode = MODE_FIQ;
        default: ;
      endcase
    end else if (pick < 75) begin
      w.action = ACT_THUMB;
    end else if (pick < 95) begin
      w.action = ACT_EXC;
      // A reset exception wipes out the pc, so keep it rarer than the rest.
      if (w.kind == EXC_RESET && $urandom_range(0, 2) != 0) begin
        w.kind = 3'($urandom_range(EXC_UND, EXC_NONE));
      end
    end else begin
      w.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    end
    return w;
  endfunction

  task automatic write_vector_cfg(logic hi);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= hi;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Checked at the rising edge, where the sender's queue and valid are settled.
  task automatic wait_until_idle();
    while (op_words.size() != 0 || in_valid_i || predicted_views.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2) @(negedge clk_i);
  endtask

  // Sender: one word at a time, held until taken, with random gaps between words.
  always @(negedge clk_i) begin : drive_ops
    op_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !in_taken)) begin
      in_taken = 1'b0;
      if (send_gap == 0 && !calm && op_words.size() != 0 && $urandom_range(0, 3) == 0) begin
        send_gap = $urandom_range(1, 10);
      end
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (op_words.size() != 0) begin
        w = op_words.pop_front();
        in_valid_i <= 1'b1;
        action_i <= w.action;
        reg_index_i <= w.reg_idx;
        write_data_i <= w.wdata;
        new_mode_i <= w.mode;
        thumb_flag_i <= w.thumb;
        exception_kind_i <= w.kind;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stalls in random bursts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : watch_ports
    reg_view_t v;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        vec_high_m = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        step_register_file(make_op(action_i, reg_index_i, write_data_i, new_mode_i,
                                   thumb_flag_i, exception_kind_i));
        in_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (predicted_views.size() == 0) begin
          $display("%0t: result word with no prediction waiting, pc %h status %h",
                   $time, program_counter_o, status_word_o);
          mismatches++;
        end else begin
          v = predicted_views.pop_front();
          check_field("read_data", v.rd, read_data_o);
          check_field("program_counter", v.pc, program_counter_o);
          check_field("current_mode", 32'(v.mode), 32'(current_mode_o));
          check_field("thumb_state", 32'(v.thumb), 32'(thumb_state_o));
          check_field("irq_masked", 32'(v.irq_m), 32'(irq_masked_o));
          check_field("fiq_masked", 32'(v.fiq_m), 32'(fiq_masked_o));
          check_field("exception_taken", 32'(v.taken), 32'(exception_taken_o));
          check_field("saved_status", v.spsr, saved_status_o);
          check_field("status_word", v.cpsr, status_word_o);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) regs_m[i] = 32'h0;
    for (int i = 0; i < NUM_SPSR; i++) spsr_m[i] = 32'h0;
    cpsr_m = 32'(STATUS_RESET);
    vec_high_m = 1'b1;
    regs_m[SLOT_PC] = VEC_HIGH_BASE;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    write_vector_cfg(1'b1);

    // Directed opening: banking per mode, wrap of the return address, masked
    // interrupts, unused codes, an unknown mode and the reset exception.
    op_words.push_back(make_op(ACT_READ, 4'd15, '0, '0, 1'b0, EXC_RESET));
    op_words.push_back(make_op(ACT_READ, REG_SP, '0, '0, 1'b0, EXC_RESET));
    op_words.push_back(make_op(ACT_WRITE, 4'd0, 32'hFFFF_FFFF, '0, 1'b0, EXC_RESET));
    op_words.push_back(make_op(ACT_WRITE, 4'd12, 32'h5A5A_5A5A, '0, 1'b0, EXC_RESET));
    op_words.push_back(make_op(ACT_WRITE, REG_LR, 32'h1234_5678, '0, 1'b0, EXC_RESET));
    op_words.push_back(make_op(ACT_MODE, '0, '0, MODE_FIQ, 1'b0, EXC_RESET));
    op_words.push_back(make_op(ACT_READ, 4'd12, '0, '0, 1'b0, EXC_RESET));
    op_words.push_back(make_op(ACT_WRITE, REG_R8, 32'hA5A5_A5A5, '0, 1'b0, EXC_RESET));
    op_words.push_back(make_op(ACT_MODE, '0, '0, MODE_USR, 1'b0, EXC_RESET));
    op_words.push_back(make_op(ACT_READ, REG_R8, '0, '0, 1'b0, EXC_RESET));
    op_words.push_back(make_op(ACT_WRITE, 4'd15, 32'hFFFF_FFFE, '0, 1'b0, EXC_RESET));
    op_words.push_back(make_op(ACT_THUMB, '0, '0, '0, 1'b1, EXC_RESET));
    op_words.push_back(make_op(ACT_EXC, '0, '0, '0, 1'b0, EXC_DABT));
    op_words.push_back(make_op(ACT_EXC, '0, '0, '0, 1'b0, EXC_PABT));
    op_words.push_back(make_op(ACT_EXC, '0, '0, '0, 1'b0, EXC_SWI));
    op_words.push_back(make_op(ACT_EXC, '0, '0, '0, 1'b0, EXC_UND));
    op_words.push_back(make_op(ACT_EXC, '0, '0, '0, 1'b0, EXC_IRQ));
    op_words.push_back(make_op(ACT_EXC, '0, '0, '0, 1'b0, EXC_FIQ));
    op_words.push_back(make_op(ACT_EXC, '0, '0, '0, 1'b0, EXC_NONE));
    op_words.push_back(make_op(ACT_SPARE_FIRST, 4'd15, 32'hFFFF_FFFF, 5'h1F, 1'b1, EXC_NONE));
    op_words.push_back(make_op(ACT_SPARE_LAST, 4'd15, 32'hFFFF_FFFF, 5'h1F, 1'b1, EXC_NONE));
    op_words.push_back(make_op(ACT_MODE, '0, '0, 5'h00, 1'b0, EXC_RESET));
    op_words.push_back(make_op(ACT_READ, REG_LR, '0, '0, 1'b0, EXC_RESET));
    op_words.push_back(make_op(ACT_EXC, '0, '0, '0, 1'b0, EXC_RESET));
    op_words.push_back(make_op(ACT_MODE, '0, '0, MODE_SYS, 1'b0, EXC_RESET));
    // The sequence holds off here until every result word of the opening is back.
    wait_until_idle();

    write_vector_cfg(1'b0);
    repeat (RANDOM_OPS) op_words.push_back(random_op());
    wait_until_idle();

    write_vector_cfg(1'b1);
    repeat (RANDOM_OPS) op_words.push_back(random_op());
    wait_until_idle();

    // Closing stretch at full rate on both sides.
    write_vector_cfg(1'b0);
    calm = 1'b1;
    repeat (RANDOM_OPS) op_words.push_back(random_op());
    wait_until_idle();
    repeat (4) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
